### rtl/kps_pkg.sv
// Shared types, constants and helpers for the keypad scanner.
package kps_pkg;

    localparam int unsigned SCAN_PERIOD_TICKS_DEF    = 10;
    localparam int unsigned REFRESH_PERIOD_TICKS_DEF = 20;

    localparam logic [7:0] LONG_PRESS_RESET    = 8'd60;
    localparam logic [7:0] RELEASE_SCANS_RESET = 8'd3;
    localparam logic       DISPLAY_EN_RESET    = 1'b0;

    localparam logic [2:0] LINES_ALL_HIGH = 3'b111;
    localparam logic [2:0] DIGIT_OFF      = 3'd4;
    localparam logic [7:0] HOLD_MAX       = 8'd255;
    localparam logic [3:0] KEY_NONE       = 4'd0;
    localparam logic [3:0] KEY_CENTER     = 4'd5;
    localparam logic [1:0] COL_LAST       = 2'd2;

    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LONG_PRESS_TICKS = 2'd0,
        CFG_RELEASE_SCANS    = 2'd1,
        CFG_DISPLAY_ENABLE   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [2:0] row_low;
        logic       clear_key;
    } in_item_t;

    typedef struct packed {
        logic [2:0] column_drive_n;
        logic [3:0] key_code;
        logic       released;
        logic       long_press;
        logic       refresh_pulse;
        logic [2:0] digit_select;
    } out_item_t;

    typedef struct packed {
        logic [7:0] long_press_ticks;
        logic [7:0] release_scans;
        logic       display_enable;
    } cfg_t;

    function automatic logic [2:0] lines_for_column(input logic [1:0] col);
        logic [2:0] lines;
        unique case (col)
            2'd0:    lines = 3'b011;
            2'd1:    lines = 3'b101;
            default: lines = 3'b110;
        endcase
        return lines;
    endfunction

endpackage

### rtl/keypad_scan_long_press.sv
// Top level of the 3x3 keypad scanner: configuration, handshake and result register.
//
// Usage: drive one transaction on the s_ channel per 5 ms tick, carrying the
// sampled row lines and the consumer's clear request. Each accepted transaction
// yields exactly one result transaction on the m_ channel with the column drive
// lines, the latched key code, release and long-press flags, the refresh pulse
// and the display digit select.
// The result is registered and becomes valid in the cycle after the transaction is accepted.
// Throughput: one transaction per cycle while s_ready is high; the state update is a single pass of
// logic into the state registers and the result register.
// Stalls: s_ready stays high while the result register is empty or being taken
// in the same cycle; with m_ready low and a result pending, s_ready drops and
// the result holds.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 long-press
// ticks, 1 release scans, 2 display enable) at the clock edge, no wait.
// Reset: aresetn low at a clock edge clears all state, drives all column lines
// high, empties the result register and restores register defaults.
module keypad_scan_long_press #(
    parameter int unsigned SCAN_PERIOD_TICKS    = kps_pkg::SCAN_PERIOD_TICKS_DEF,
    parameter int unsigned REFRESH_PERIOD_TICKS = kps_pkg::REFRESH_PERIOD_TICKS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  kps_pkg::in_item_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output kps_pkg::out_item_t                  m_data,
    input  logic                                cfg_we,
    input  logic [kps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [kps_pkg::CFG_DATA_W-1:0]      cfg_data
);

    kps_pkg::cfg_t      cfg_reg;
    kps_pkg::out_item_t result;
    kps_pkg::out_item_t m_data_reg;
    logic               m_valid_reg;
    logic               accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_press_ticks <= kps_pkg::LONG_PRESS_RESET;
            cfg_reg.release_scans    <= kps_pkg::RELEASE_SCANS_RESET;
            cfg_reg.display_enable   <= kps_pkg::DISPLAY_EN_RESET;
        end else if (cfg_we) begin
            unique case (kps_pkg::cfg_index_t'(cfg_index))
                kps_pkg::CFG_LONG_PRESS_TICKS: cfg_reg.long_press_ticks <= cfg_data;
                kps_pkg::CFG_RELEASE_SCANS:    cfg_reg.release_scans    <= cfg_data;
                kps_pkg::CFG_DISPLAY_ENABLE:   cfg_reg.display_enable   <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    kps_core #(
        .SCAN_PERIOD_TICKS    (SCAN_PERIOD_TICKS),
        .REFRESH_PERIOD_TICKS (REFRESH_PERIOD_TICKS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept),
        .item    (s_data),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

endmodule

### rtl/kps_core.sv
// Scanner state and its per-transaction update.
module kps_core #(
    parameter int unsigned SCAN_PERIOD_TICKS    = kps_pkg::SCAN_PERIOD_TICKS_DEF,
    parameter int unsigned REFRESH_PERIOD_TICKS = kps_pkg::REFRESH_PERIOD_TICKS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  kps_pkg::in_item_t  item,
    input  kps_pkg::cfg_t      cfg,
    output kps_pkg::out_item_t result
);

    localparam int unsigned SCAN_W = (SCAN_PERIOD_TICKS > 1) ? $clog2(SCAN_PERIOD_TICKS) : 1;
    localparam int unsigned REFR_W =
        (REFRESH_PERIOD_TICKS > 1) ? $clog2(REFRESH_PERIOD_TICKS) : 1;
    localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(SCAN_PERIOD_TICKS - 1);
    localparam logic [REFR_W-1:0] REFR_LAST = REFR_W'(REFRESH_PERIOD_TICKS - 1);
    localparam logic [1:0] COL_LAST = kps_pkg::COL_LAST;

    logic [REFR_W-1:0] tick_phase_reg, tick_phase_next;
    logic [SCAN_W-1:0] scan_phase_reg, scan_phase_next;
    logic [1:0]        digit_phase_reg, digit_phase_next;
    logic [31:0]       scan_count_reg, scan_count_next;
    logic [31:0]       press_stamp_reg, press_stamp_next;
    logic [1:0]        active_column_reg, active_column_next;
    logic [2:0]        column_lines_reg, column_lines_next;
    logic              detect_armed_reg, detect_armed_next;
    logic [3:0]        latched_key_reg, latched_key_next;
    logic              release_flag_reg, release_flag_next;
    logic [7:0]        hold_count_reg, hold_count_next;
    logic              long_flag_reg, long_flag_next;

    logic       refresh;
    logic       scan_wrap;
    logic [1:0] row_idx;
    logic [1:0] col_idx;
    logic [3:0] key_pressed;
    logic [31:0] since_press;

    always_comb begin
        row_idx = item.row_low[0] ? 2'd0 : (item.row_low[1] ? 2'd1 : 2'd2);
        col_idx = (active_column_reg > COL_LAST) ? COL_LAST : active_column_reg;
        key_pressed = 4'd9 - ({2'b00, col_idx} + {1'b0, col_idx, 1'b0}) - {2'b00, row_idx};

        detect_armed_next  = detect_armed_reg;
        press_stamp_next   = press_stamp_reg;
        release_flag_next  = release_flag_reg;
        column_lines_next  = column_lines_reg;
        latched_key_next   = item.clear_key ? kps_pkg::KEY_NONE : latched_key_reg;

        if (detect_armed_reg && (item.row_low != 3'd0)) begin
            detect_armed_next = 1'b0;
            press_stamp_next  = scan_count_reg;
            release_flag_next = 1'b0;
            latched_key_next  = key_pressed;
            column_lines_next = kps_pkg::LINES_ALL_HIGH;
        end

        hold_count_next = hold_count_reg;
        long_flag_next  = long_flag_reg;
        if ((latched_key_next != kps_pkg::KEY_NONE)
                && (latched_key_next != kps_pkg::KEY_CENTER)) begin
            if (hold_count_reg != kps_pkg::HOLD_MAX) begin
                hold_count_next = hold_count_reg + 8'd1;
            end
            if (hold_count_next > cfg.long_press_ticks) begin
                long_flag_next = 1'b1;
            end
        end else begin
            hold_count_next = 8'd0;
            long_flag_next  = 1'b0;
        end

        digit_phase_next = digit_phase_reg + 2'd1;

        refresh         = (tick_phase_reg == REFR_LAST);
        tick_phase_next = refresh ? '0 : tick_phase_reg + REFR_W'(1);

        scan_wrap       = (scan_phase_reg == SCAN_LAST);
        scan_phase_next = scan_wrap ? '0 : scan_phase_reg + SCAN_W'(1);

        scan_count_next    = scan_count_reg;
        active_column_next = active_column_reg;
        since_press        = scan_count_reg + 32'd1 - press_stamp_next;
        if (scan_wrap) begin
            scan_count_next    = scan_count_reg + 32'd1;
            active_column_next = (active_column_reg >= COL_LAST) ? 2'd0
                                                                 : active_column_reg + 2'd1;
            column_lines_next  = kps_pkg::lines_for_column(active_column_next);
            detect_armed_next  = 1'b1;
            if (since_press > {24'd0, cfg.release_scans}) begin
                release_flag_next = 1'b1;
            end
        end

        result.column_drive_n = column_lines_next;
        result.key_code       = latched_key_next;
        result.released       = release_flag_next;
        result.long_press     = long_flag_next;
        result.refresh_pulse  = refresh;
        result.digit_select   = cfg.display_enable ? {1'b0, digit_phase_next}
                                                   : kps_pkg::DIGIT_OFF;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_phase_reg    <= '0;
            scan_phase_reg    <= '0;
            digit_phase_reg   <= '0;
            scan_count_reg    <= '0;
            press_stamp_reg   <= '0;
            active_column_reg <= '0;
            column_lines_reg  <= kps_pkg::LINES_ALL_HIGH;
            detect_armed_reg  <= 1'b0;
            latched_key_reg   <= kps_pkg::KEY_NONE;
            release_flag_reg  <= 1'b0;
            hold_count_reg    <= '0;
            long_flag_reg     <= 1'b0;
        end else if (step) begin
            tick_phase_reg    <= tick_phase_next;
            scan_phase_reg    <= scan_phase_next;
            digit_phase_reg   <= digit_phase_next;
            scan_count_reg    <= scan_count_next;
            press_stamp_reg   <= press_stamp_next;
            active_column_reg <= active_column_next;
            column_lines_reg  <= column_lines_next;
            detect_armed_reg  <= detect_armed_next;
            latched_key_reg   <= latched_key_next;
            release_flag_reg  <= release_flag_next;
            hold_count_reg    <= hold_count_next;
            long_flag_reg     <= long_flag_next;
        end
    end

endmodule

### bench/keypad_scan_long_press_tb.sv
// Self-checking bench for keypad_scan_long_press: a directed tick table, then random bursts.
module testbench;
    import kps_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int DIRECTED_ROWS = 24;
    localparam int PHASES        = 5;
    localparam int PHASE_TICKS   = 306;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } tick_row_t;

    localparam out_item_t NO_TYPED = '0;

    localparam tick_row_t DIRECTED_TICKS [DIRECTED_ROWS] = '{
        '{'{3'd0, 1'b0}, 1'b1, '{LINES_ALL_HIGH, KEY_NONE, 1'b0, 1'b0, 1'b0, DIGIT_OFF}},
        '{'{3'd7, 1'b0}, 1'b0, NO_TYPED},
        '{'{3'd1, 1'b1}, 1'b0, NO_TYPED},
        '{'{3'd2, 1'b0}, 1'b0, NO_TYPED},
        '{'{3'd4, 1'b1}, 1'b0, NO_TYPED},
        '{'{3'd3, 1'b0}, 1'b0, NO_TYPED},
        '{'{3'd5, 1'b0}, 1'b0, NO_TYPED},
        '{'{3'd6, 1'b1}, 1'b0, NO_TYPED},
        '{'{3'd0, 1'b0}, 1'b0, NO_TYPED},
        '{'{3'd0, 1'b0}, 1'b0, NO_TYPED},
        '{'{3'd6, 1'b1}, 1'b0, NO_TYPED},
        '{'{3'd7, 1'b0}, 1'b0, NO_TYPED},
        '{'{3'd0, 1'b0}, 1'b0, NO_TYPED},
        '{'{3'd0, 1'b0}, 1'b0, NO_TYPED},
        '{'{3'd0, 1'b1}, 1'b0, NO_TYPED},
        '{'{3'd0, 1'b0}, 1'b0, NO_TYPED},
        '{'{3'd0, 1'b0}, 1'b0, NO_TYPED},
        '{'{3'd0, 1'b0}, 1'b0, NO_TYPED},
        '{'{3'd0, 1'b0}, 1'b0, NO_TYPED},
        '{'{3'd0, 1'b0}, 1'b0, NO_TYPED},
        '{'{3'd4, 1'b0}, 1'b0, NO_TYPED},
        '{'{3'd1, 1'b0}, 1'b0, NO_TYPED},
        '{'{3'd0, 1'b1}, 1'b0, NO_TYPED},
        '{'{3'd7, 1'b0}, 1'b0, NO_TYPED}
    };

    localparam logic [7:0] PHASE_LONG_PRESS [PHASES] = '{8'd1, 8'd255, 8'd7, 8'd0, 8'd30};
    localparam logic [7:0] PHASE_RELEASE    [PHASES] = '{8'd1, 8'd255, 8'd2, 8'd0, 8'd5};
    localparam logic [7:0] PHASE_DISPLAY    [PHASES] = '{8'h01, 8'h00, 8'hFF, 8'hFE, 8'h01};
    localparam int         PHASE_SEND_IDLE  [PHASES] = '{0, 50, 0, 18, 0};
    localparam int         PHASE_RECV_STALL [PHASES] = '{0, 0, 50, 18, 0};

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;
    logic       cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int unsigned error_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    out_item_t   pending_outputs [$];

    logic [7:0]  long_press_limit;
    logic [7:0]  release_limit;
    logic        digit_enable;
    int unsigned refresh_ctr;
    int unsigned scan_ctr;
    logic [1:0]  digit_ctr;
    logic [31:0] scan_total;
    logic [31:0] press_scan;
    logic [1:0]  column_sel;
    logic [2:0]  drive_lines;
    logic        scan_armed;
    logic [3:0]  held_key;
    logic        release_seen;
    logic [7:0]  hold_ticks;
    logic        long_seen;

    keypad_scan_long_press i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    task automatic reset_keypad_state();
        long_press_limit = LONG_PRESS_RESET;
        release_limit    = RELEASE_SCANS_RESET;
        digit_enable     = DISPLAY_EN_RESET;
        refresh_ctr      = 0;
        scan_ctr         = 0;
        digit_ctr        = '0;
        scan_total       = '0;
        press_scan       = '0;
        column_sel       = '0;
        drive_lines      = LINES_ALL_HIGH;
        scan_armed       = 1'b0;
        held_key         = KEY_NONE;
        release_seen     = 1'b0;
        hold_ticks       = '0;
        long_seen        = 1'b0;
    endtask

    function automatic out_item_t next_keypad_outputs(input in_item_t item);
        logic [3:0] row_idx;
        logic       refresh;
        out_item_t  res;
        if (item.clear_key)
            held_key = KEY_NONE;
        if (scan_armed && item.row_low != 3'b000) begin
            row_idx      = item.row_low[0] ? 4'd0 : (item.row_low[1] ? 4'd1 : 4'd2);
            scan_armed   = 1'b0;
            press_scan   = scan_total;
            release_seen = 1'b0;
            held_key     = 4'd9 - 4'd3 * {2'b00, column_sel} - row_idx;
            drive_lines  = LINES_ALL_HIGH;
        end
        if (held_key != KEY_NONE && held_key != KEY_CENTER) begin
            if (hold_ticks != 8'd255)
                hold_ticks = hold_ticks + 8'd1;
            if (hold_ticks > long_press_limit)
                long_seen = 1'b1;
        end else begin
            hold_ticks = '0;
            long_seen  = 1'b0;
        end
        digit_ctr   = digit_ctr + 2'd1;
        refresh     = (refresh_ctr + 1 >= REFRESH_PERIOD_TICKS_DEF);
        refresh_ctr = refresh ? 0 : refresh_ctr + 1;
        if (scan_ctr + 1 >= SCAN_PERIOD_TICKS_DEF) begin
            scan_ctr    = 0;
            scan_total  = scan_total + 32'd1;
            column_sel  = (column_sel == 2'd2) ? 2'd0 : column_sel + 2'd1;
            drive_lines = ~(3'b100 >> column_sel);
            scan_armed  = 1'b1;
            if (scan_total - press_scan > {24'd0, release_limit})
                release_seen = 1'b1;
        end else begin
            scan_ctr = scan_ctr + 1;
        end
        res.column_drive_n = drive_lines;
        res.key_code       = held_key;
        res.released       = release_seen;
        res.long_press     = long_seen;
        res.refresh_pulse  = refresh;
        res.digit_select   = digit_enable ? {1'b0, digit_ctr} : DIGIT_OFF;
        return res;
    endfunction

    task automatic load_settings(input logic [7:0] lp, input logic [7:0] rs,
                                 input logic [7:0] de_raw, input bit poke_spare);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LONG_PRESS_TICKS;
        cfg_data  <= lp;
        @(posedge aclk);
        cfg_index <= CFG_RELEASE_SCANS;
        cfg_data  <= rs;
        @(posedge aclk);
        cfg_index <= CFG_DISPLAY_ENABLE;
        cfg_data  <= de_raw;
        @(posedge aclk);
        if (poke_spare) begin
            cfg_index <= CFG_SPARE;
            cfg_data  <= 8'hA5;
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        long_press_limit = lp;
        release_limit    = rs;
        digit_enable     = de_raw[0];
    endtask

    task automatic present_tick(input in_item_t item, input logic typed, input out_item_t want);
        out_item_t predicted;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        predicted = next_keypad_outputs(item);
        pending_outputs.push_back(typed ? want : predicted);
    endtask

    task automatic report_field(input string field, input logic [3:0] want, input logic [3:0] got);
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        error_count++;
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (pending_outputs.size() == 0) begin
            $display("%0t: result %h with nothing expected", $time, got);
            error_count++;
            return;
        end
        want = pending_outputs.pop_front();
        if (got.column_drive_n !== want.column_drive_n)
            report_field("column_drive_n", want.column_drive_n, got.column_drive_n);
        if (got.key_code !== want.key_code)
            report_field("key_code", want.key_code, got.key_code);
        if (got.released !== want.released)
            report_field("released", want.released, got.released);
        if (got.long_press !== want.long_press)
            report_field("long_press", want.long_press, got.long_press);
        if (got.refresh_pulse !== want.refresh_pulse)
            report_field("refresh_pulse", want.refresh_pulse, got.refresh_pulse);
        if (got.digit_select !== want.digit_select)
            report_field("digit_select", want.digit_select, got.digit_select);
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                check_result(m_data);
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        in_item_t stim;
        int       remaining;
        int       burst_kind;
        int       burst_len;
        reset_keypad_state();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < DIRECTED_ROWS; i++)
            present_tick(DIRECTED_TICKS[i].item, DIRECTED_TICKS[i].typed, DIRECTED_TICKS[i].want);
        s_valid <= 1'b0;
        for (int p = 0; p < PHASES; p++) begin
            while (pending_outputs.size() != 0) @(posedge aclk);
            @(posedge aclk);
            load_settings(PHASE_LONG_PRESS[p], PHASE_RELEASE[p], PHASE_DISPLAY[p], p == 3);
            send_idle_pct  = PHASE_SEND_IDLE[p];
            recv_stall_pct = PHASE_RECV_STALL[p];
            remaining = PHASE_TICKS;
            while (remaining > 0) begin
                burst_kind = $urandom_range(0, 9);
                burst_len  = (burst_kind == 7) ? $urandom_range(1, 3) : $urandom_range(1, 80);
                for (int k = 0; k < burst_len && remaining > 0; k++) begin
                    if (burst_kind <= 3) begin
                        stim = '{3'd0, 1'b0};
                    end else if (burst_kind <= 6) begin
                        stim = '{3'($urandom_range(1, 7)), 1'b0};
                    end else if (burst_kind == 7) begin
                        stim = '{3'($urandom_range(0, 1) ? 0 : $urandom_range(1, 7)), 1'b1};
                    end else begin
                        stim = '{3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))};
                    end
                    present_tick(stim, 1'b0, NO_TYPED);
                    remaining--;
                end
            end
            s_valid <= 1'b0;
        end
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0)
            $display("keypad_scan_long_press verification clean");
        else
            $display("keypad_scan_long_press verification failed");
        $finish;
    end

    initial begin
        #(CLK_PERIOD * 400000);
        $display("keypad_scan_long_press verification failed");
        $finish;
    end

endmodule
